FILE: rtl/keyed_state_table_with_eviction_defines.svh
// Assertion macros for the keyed state table.
// Taken in by keyed_state_table_with_eviction, which carries concurrent checks; depends on nothing else.
`ifndef KEYED_STATE_TABLE_WITH_EVICTION_DEFINES_SVH
`define KEYED_STATE_TABLE_WITH_EVICTION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KSTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed state table check failed");

// Next-cycle implication, disabled during reset.
`define KSTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed state table check failed");

`endif

FILE: rtl/kste_pkg.sv
// Shared types and constants of the keyed state table.
// Used by kste_cell and keyed_state_table_with_eviction; depends on nothing.
package kste_pkg;

   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int ENTRIES_DEFAULT = 16;
   localparam int REQ_TDATA_W     = KEY_W + VALUE_W;
   localparam int RSP_TDATA_W     = VALUE_W;

   // Item kinds carried on the request tuser bit.
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic write;  // an accepted write beat
      logic miss;   // its key matches no valid cell
   } cell_ctrl_type;

endpackage

FILE: rtl/kste_cell.sv
// One slot of the table: a key, a value and a valid flag.
// Depends on kste_pkg; instantiated in a row by keyed_state_table_with_eviction.
module kste_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kste_pkg::cell_ctrl_type ctrl,
   input  kste_pkg::key_type      item_key,
   input  kste_pkg::value_type    item_value,
   input  logic                   prev_valid,
   input  logic                   shift_in,
   input  kste_pkg::key_type      next_key,
   input  kste_pkg::value_type    next_value,
   input  logic                   next_valid,
   output kste_pkg::key_type      key,
   output kste_pkg::value_type    value,
   output logic                   valid,
   output logic                   hit,
   output logic                   shift_out
);

   kste_pkg::key_type   key_ff, key_in;
   kste_pkg::value_type value_ff, value_in;
   logic                valid_ff, valid_in;

   // Key compare and the shift chain towards the newer end.
   assign hit       = valid_ff && (key_ff == item_key);
   assign shift_out = shift_in || (ctrl.write && hit);

   // A shifting cell takes its newer neighbour, or the new item if it was the newest.
   // An empty cell directly after the newest one takes a missing key's item.
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      if (shift_out && valid_ff) begin
         if (next_valid) begin
            key_in   = next_key;
            value_in = next_value;
         end else begin
            key_in   = item_key;
            value_in = item_value;
         end
      end else if (ctrl.write && ctrl.miss && !valid_ff && prev_valid) begin
         key_in   = item_key;
         value_in = item_value;
         valid_in = 1'b1;
      end
   end

   // Valid flag is control state; key and value are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/keyed_state_table_with_eviction.sv
// Top level of the keyed state table: a row of kste_cell slots and the result register.
// Depends on kste_pkg, kste_cell and keyed_state_table_with_eviction_defines.svh.
//
// Usage: each request beat carries a key and, for writes, a new value; tuser selects
// read or write. A read returns one response beat with a found flag and the stored
// value (zero when absent). A write returns nothing: a present key is updated and
// becomes the newest entry; an absent key is appended, the oldest entry being dropped
// first when all ENTRIES cells are in use.
// A read response is registered and presented in the cycle after its request beat is taken.
// Throughput: one item per cycle while req_tready is high. Every cell compares its key in parallel and moves
// one slot along the row in the same cycle, so the row of cells never holds requests back.
// Reset clears every valid flag, so the table starts empty at once; no clearing pass.
// When the receiver stalls, the held response stays put and new requests are taken
// only while the response register is empty or being emptied in that cycle.
`include "keyed_state_table_with_eviction_defines.svh"

module keyed_state_table_with_eviction #(
   parameter int ENTRIES = kste_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kste_pkg::REQ_TDATA_W-1:0]   req_tdata,  // key, new_value
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kste_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // value
   output logic                               rsp_tuser   // found
);

   kste_pkg::key_type       item_key;
   kste_pkg::value_type     item_value;
   logic                    accept;
   logic                    is_write;
   logic                    any_hit;
   logic                    full;
   kste_pkg::cell_ctrl_type ctrl;

   kste_pkg::key_type       cell_key   [ENTRIES];
   kste_pkg::value_type     cell_value [ENTRIES];
   logic [ENTRIES-1:0]      valid_vec;
   logic [ENTRIES-1:0]      hit_vec;
   logic [ENTRIES:0]        shift_c;

   kste_pkg::value_type     read_value;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   kste_pkg::value_type     rsp_value_ff, rsp_value_in;

   // Request unpacking and handshake.
   assign item_key   = req_tdata[kste_pkg::KEY_W-1:0];
   assign item_value = req_tdata[kste_pkg::REQ_TDATA_W-1:kste_pkg::KEY_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_write   = accept && (req_tuser == kste_pkg::MODE_WRITE);

   // Broadcast control; a write that misses on a full table shifts the whole row.
   assign any_hit    = |hit_vec;
   assign full       = valid_vec[ENTRIES-1];
   assign ctrl.write = is_write;
   assign ctrl.miss  = !any_hit;
   assign shift_c[0] = is_write && !any_hit && full;

   // The row of cells, slot 0 oldest.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic                prev_valid;
      kste_pkg::key_type   next_key;
      kste_pkg::value_type next_value;
      logic                next_valid;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_vec[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign next_key   = '0;
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_inner
         assign next_key   = cell_key[i+1];
         assign next_value = cell_value[i+1];
         assign next_valid = valid_vec[i+1];
      end

      kste_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .item_key   (item_key),
         .item_value (item_value),
         .prev_valid (prev_valid),
         .shift_in   (shift_c[i]),
         .next_key   (next_key),
         .next_value (next_value),
         .next_valid (next_valid),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .valid      (valid_vec[i]),
         .hit        (hit_vec[i]),
         .shift_out  (shift_c[i+1])
      );
   end

   // Read data: at most one cell matches, so the masked values are OR-ed together.
   always_comb begin
      read_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         read_value = read_value | (cell_value[i] & {kste_pkg::VALUE_W{hit_vec[i]}});
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && (req_tuser == kste_pkg::MODE_READ)) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = any_hit;
         rsp_value_in = read_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_found_ff;

   // Occupied cells always form a run from the oldest slot.
   `KSTE_ASSERT_NOW(a_valid_prefix, clock, reset, 1'b1,
      (valid_vec & (valid_vec + ENTRIES'(1))) == {ENTRIES{1'b0}})
   // No key is held twice.
   `KSTE_ASSERT_NOW(a_single_hit, clock, reset, 1'b1, $onehot0(hit_vec))
   // A new key on a table with room adds exactly one entry.
   `KSTE_ASSERT_NEXT(a_append_grows, clock, reset, is_write && !any_hit && !full,
      $countones(valid_vec) == $past($countones(valid_vec)) + 1)
   // Every accepted read presents a response in the next cycle.
   `KSTE_ASSERT_NEXT(a_read_responds, clock, reset,
      accept && (req_tuser == kste_pkg::MODE_READ), rsp_tvalid)

endmodule
